@@ src/fpc_pkg.sv @@
`timescale 1ns / 1ps

package fpc_pkg;

    // Defaults for the top level parameters
    localparam int DATA_WIDTH_DEF = 32;
    localparam int RADIUS_DEF     = 65536;

    // Fixed point: Q16.16 data, Q1.16 filter weights
    localparam int FRAC_W = 16;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Serial multiplier geometry
    localparam int MD_W  = 33;  // multiplicand: data word or a difference of two
    localparam int MR_W  = 36;  // multiplier: gain or alpha, padded to whole digits
    localparam int DIG_W = 4;   // multiplier bits retired per cycle
    localparam int Q_W   = 50;  // product shifted right by FRAC_W
    localparam int SUM_W = 49;  // integral term and output sum before clamping

    localparam int CFG_IDX_W = 4;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUT_MAX     = 4'd0,
        CFG_OUT_MIN     = 4'd1,
        CFG_KP          = 4'd2,
        CFG_KI_TIMES_DT = 4'd3,
        CFG_KD_OVER_DT  = 4'd4,
        CFG_ALPHA_P     = 4'd5,
        CFG_ALPHA_D     = 4'd6,
        CFG_INTEG_LIMIT = 4'd7
    } cfg_index_t;

    // Sample sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_ERR,
        S_P_MUL,
        S_P_BLEND,
        S_I_MUL,
        S_D_MUL,
        S_D_BLEND,
        S_SUM,
        S_OUT
    } fpc_state_t;

    // Multiplier status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

endpackage

@@ src/fpc_serial_mul.sv @@
`timescale 1ns / 1ps

// Signed digit-serial multiplier, least significant digit first.
// The multiplier operand is retired DIG_W bits per cycle; its top digit is signed.
module fpc_serial_mul (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [fpc_pkg::MD_W-1:0]      md,
    input  logic        [fpc_pkg::MR_W-1:0]      mr,
    output fpc_pkg::mul_status_t                 status,
    output logic signed [fpc_pkg::Q_W-1:0]       q
);

    localparam int MDW  = fpc_pkg::MD_W;
    localparam int MRW  = fpc_pkg::MR_W;
    localparam int DGW  = fpc_pkg::DIG_W;
    localparam int QW   = fpc_pkg::Q_W;
    localparam int FRAC = fpc_pkg::FRAC_W;
    localparam int NDIG = MRW / DGW;
    localparam int CW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int HW   = MDW + DGW + 1;
    localparam int PW   = HW + MRW;

    logic signed [MDW-1:0] md_reg, md_next;
    logic        [MRW-1:0] mr_reg, mr_next;
    logic signed [HW-1:0]  hi_reg, hi_next;
    logic        [MRW-1:0] lo_reg, lo_next;
    logic        [CW-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic                  last_dig;
    logic        [DGW-1:0] dig;
    logic signed [DGW:0]   dig_s;
    logic signed [HW-1:0]  pp;
    logic signed [HW-1:0]  step;
    logic        [PW-1:0]  prod_full;

    // One digit of partial product per cycle
    assign last_dig = (cnt_reg == CW'(NDIG - 1));
    assign dig      = mr_reg[DGW-1:0];
    assign dig_s    = last_dig ? $signed({dig[DGW-1], dig}) : $signed({1'b0, dig});
    assign pp       = HW'(md_reg) * HW'(dig_s);
    assign step     = hi_reg + pp;

    assign prod_full = {hi_reg, lo_reg};
    assign q         = $signed(prod_full[FRAC +: QW]);
    assign status    = '{busy: busy_reg, done: done_reg};

    // Load, iterate, flag completion
    always_comb
    begin
        md_next   = md_reg;
        mr_next   = mr_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            md_next   = md;
            mr_next   = mr;
            hi_next   = '0;
            lo_next   = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next  = step >>> DGW;
            lo_next  = {step[DGW-1:0], lo_reg[MRW-1:DGW]};
            mr_next  = mr_reg >> DGW;
            cnt_next = cnt_reg + CW'(1);
            if (last_dig)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        md_reg <= md_next;
        mr_reg <= mr_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

endmodule

@@ src/filtered_pid_controller.sv @@
`timescale 1ns / 1ps

// PID controller with low-pass filtered proportional and derivative terms, signed Q16.16
// throughout. One sample request (target, measured, restart) yields one drive value,
// clamped to [out_min, out_max]. The block works one sample at a time: a new sample is
// taken only after the last one has made five passes through one shared multiplier that
// retires four multiplier bits per cycle (kp*error, P blend, ki*integrator, kd*delta
// error, D blend) and its drive value has been registered. A result may wait on
// out_stall while the next sample is already accepted and computed. Restart clears the
// integrator, the previous error and the D filter before the sample is used; the P filter
// is kept. Alphas with low 17 bits above 65536 are stored as 65536. Registers are written
// through the cfg port, which is always ready; write only while no sample is in flight.
module filtered_pid_controller #(
    parameter int DATA_WIDTH   = fpc_pkg::DATA_WIDTH_DEF,
    parameter int INTEG_RADIUS = fpc_pkg::RADIUS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // sample input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [31:0]              target,
    input  logic signed [31:0]              measured,
    input  logic                            restart,
    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              drive,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                     cfg_data
);

    localparam int QW  = fpc_pkg::Q_W;
    localparam int MDW = fpc_pkg::MD_W;
    localparam int MRW = fpc_pkg::MR_W;
    localparam int SW  = fpc_pkg::SUM_W;
    localparam int DW  = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;

    localparam logic signed [QW-1:0]  SAT_HI = QW'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam logic signed [QW-1:0]  SAT_LO = QW'(-(64'sd1 <<< (DW - 1)));
    localparam logic signed [MDW-1:0] RADIUS = MDW'(INTEG_RADIUS);

    function automatic logic signed [31:0] sat_dw(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] r;
        r = v;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        return r[31:0];
    endfunction

    // configuration registers
    logic signed [31:0] out_max_reg, out_max_next;
    logic signed [31:0] out_min_reg, out_min_next;
    logic signed [31:0] kp_reg, kp_next;
    logic signed [31:0] ki_reg, ki_next;
    logic signed [31:0] kd_reg, kd_next;
    logic [16:0]        alpha_p_reg, alpha_p_next;
    logic [16:0]        alpha_d_reg, alpha_d_next;
    logic [30:0]        integ_limit_reg, integ_limit_next;
    logic [16:0]        alpha_wr;

    // controller state
    fpc_pkg::fpc_state_t state_reg, state_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [31:0] last_err_reg, last_err_next;
    logic signed [31:0] p_filt_reg, p_filt_next;
    logic signed [31:0] d_filt_reg, d_filt_next;
    logic               out_valid_reg, out_valid_next;

    // per-sample working values
    logic signed [31:0] target_reg, target_next;
    logic signed [31:0] measured_reg, measured_next;
    logic signed [31:0] err_reg, err_next;
    logic signed [31:0] praw_reg, praw_next;
    logic signed [31:0] draw_reg, draw_next;
    logic signed [SW-1:0] iterm_reg, iterm_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [31:0] drive_reg, drive_next;

    // multiplier hookup
    logic                    mul_start;
    logic signed [MDW-1:0]   mul_md;
    logic        [MRW-1:0]   mul_mr;
    fpc_pkg::mul_status_t    mul_st;
    logic signed [QW-1:0]    mul_q;

    // datapath helpers
    logic signed [MDW-1:0] diff_in;
    logic signed [31:0]    err_c;
    logic signed [31:0]    sat_q;
    logic signed [MDW-1:0] err_ext;
    logic signed [MDW-1:0] mag;
    logic signed [MDW-1:0] acc;
    logic signed [MDW-1:0] lim;
    logic signed [MDW-1:0] acc_clamped;
    logic signed [31:0]    integ_c;
    logic signed [MDW-1:0] d_diff;
    logic signed [SW-1:0]  sum_c;
    logic signed [31:0]    drive_c;
    logic                  in_accept;

    fpc_serial_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .md     (mul_md),
        .mr     (mul_mr),
        .status (mul_st),
        .q      (mul_q)
    );

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != fpc_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // error, saturated product
    assign diff_in = MDW'(target_reg) - MDW'(measured_reg);
    assign err_c   = sat_dw(QW'(diff_in));
    assign sat_q   = sat_dw(mul_q);

    // integrator with conditional accumulation and limit clamp
    assign err_ext = MDW'(err_reg);
    assign mag     = err_ext[MDW-1] ? -err_ext : err_ext;
    assign acc     = MDW'(integ_reg) + ((mag < RADIUS) ? err_ext : '0);
    assign lim     = $signed({2'b00, integ_limit_reg});
    always_comb
    begin
        acc_clamped = acc;
        if (acc > lim)
            acc_clamped = lim;
        else if (acc < -lim)
            acc_clamped = -lim;
    end
    assign integ_c = sat_dw(QW'(acc_clamped));

    assign d_diff = MDW'(err_reg) - MDW'(last_err_reg);

    // output sum and clamp; with crossed bounds, sums above out_max give out_max, all others out_min
    assign sum_c = SW'(p_filt_reg) + iterm_reg + SW'(d_filt_reg);
    always_comb
    begin
        if (sum_reg > SW'(out_max_reg))
            drive_c = out_max_reg;
        else if (sum_reg < SW'(out_min_reg))
            drive_c = out_min_reg;
        else
            drive_c = sum_reg[31:0];
    end

    // register writes
    always_comb
    begin
        alpha_wr         = (cfg_data[16:0] > fpc_pkg::ONE_Q16) ? fpc_pkg::ONE_Q16
                                                               : cfg_data[16:0];
        out_max_next     = out_max_reg;
        out_min_next     = out_min_reg;
        kp_next          = kp_reg;
        ki_next          = ki_reg;
        kd_next          = kd_reg;
        alpha_p_next     = alpha_p_reg;
        alpha_d_next     = alpha_d_reg;
        integ_limit_next = integ_limit_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                fpc_pkg::CFG_OUT_MAX:     out_max_next     = cfg_data;
                fpc_pkg::CFG_OUT_MIN:     out_min_next     = cfg_data;
                fpc_pkg::CFG_KP:          kp_next          = cfg_data;
                fpc_pkg::CFG_KI_TIMES_DT: ki_next          = cfg_data;
                fpc_pkg::CFG_KD_OVER_DT:  kd_next          = cfg_data;
                fpc_pkg::CFG_ALPHA_P:     alpha_p_next     = alpha_wr;
                fpc_pkg::CFG_ALPHA_D:     alpha_d_next     = alpha_wr;
                fpc_pkg::CFG_INTEG_LIMIT: integ_limit_next = cfg_data[30:0];
                default:                  ;
            endcase
        end
    end

    // sample sequencer
    always_comb
    begin
        state_next     = state_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        p_filt_next    = p_filt_reg;
        d_filt_next    = d_filt_reg;
        out_valid_next = out_valid_reg;
        target_next    = target_reg;
        measured_next  = measured_reg;
        err_next       = err_reg;
        praw_next      = praw_reg;
        draw_next      = draw_reg;
        iterm_next     = iterm_reg;
        sum_next       = sum_reg;
        drive_next     = drive_reg;
        mul_start      = 1'b0;
        mul_md         = '0;
        mul_mr         = '0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            fpc_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    target_next   = target;
                    measured_next = measured;
                    if (restart)
                    begin
                        integ_next    = '0;
                        last_err_next = '0;
                        d_filt_next   = '0;
                    end
                    state_next = fpc_pkg::S_ERR;
                end
            end
            fpc_pkg::S_ERR:
            begin
                err_next   = err_c;
                mul_start  = 1'b1;
                mul_md     = MDW'(err_c);
                mul_mr     = MRW'(kp_reg);
                state_next = fpc_pkg::S_P_MUL;
            end
            fpc_pkg::S_P_MUL:
            begin
                if (mul_st.done)
                begin
                    praw_next  = sat_q;
                    mul_start  = 1'b1;
                    mul_md     = MDW'(p_filt_reg) - MDW'(sat_q);
                    mul_mr     = MRW'(alpha_p_reg);
                    state_next = fpc_pkg::S_P_BLEND;
                end
            end
            fpc_pkg::S_P_BLEND:
            begin
                if (mul_st.done)
                begin
                    // blend = x + floor(alpha * (prev - x) / 2^16), stays between x and prev
                    p_filt_next = praw_reg + mul_q[31:0];
                    integ_next  = integ_c;
                    mul_start   = 1'b1;
                    mul_md      = MDW'(integ_c);
                    mul_mr      = MRW'(ki_reg);
                    state_next  = fpc_pkg::S_I_MUL;
                end
            end
            fpc_pkg::S_I_MUL:
            begin
                if (mul_st.done)
                begin
                    iterm_next    = mul_q[SW-1:0];
                    last_err_next = err_reg;
                    mul_start     = 1'b1;
                    mul_md        = d_diff;
                    mul_mr        = MRW'(kd_reg);
                    state_next    = fpc_pkg::S_D_MUL;
                end
            end
            fpc_pkg::S_D_MUL:
            begin
                if (mul_st.done)
                begin
                    draw_next  = sat_q;
                    mul_start  = 1'b1;
                    mul_md     = MDW'(d_filt_reg) - MDW'(sat_q);
                    mul_mr     = MRW'(alpha_d_reg);
                    state_next = fpc_pkg::S_D_BLEND;
                end
            end
            fpc_pkg::S_D_BLEND:
            begin
                if (mul_st.done)
                begin
                    d_filt_next = draw_reg + mul_q[31:0];
                    state_next  = fpc_pkg::S_SUM;
                end
            end
            fpc_pkg::S_SUM:
            begin
                sum_next   = sum_c;
                state_next = fpc_pkg::S_OUT;
            end
            fpc_pkg::S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    drive_next     = drive_c;
                    out_valid_next = 1'b1;
                    state_next     = fpc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fpc_pkg::S_IDLE;
            end
        endcase
    end

    // control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fpc_pkg::S_IDLE;
            out_valid_reg   <= 1'b0;
            integ_reg       <= '0;
            last_err_reg    <= '0;
            p_filt_reg      <= '0;
            d_filt_reg      <= '0;
            out_max_reg     <= 32'sh7FFF_FFFF;
            out_min_reg     <= 32'sh8000_0000;
            kp_reg          <= '0;
            ki_reg          <= '0;
            kd_reg          <= '0;
            alpha_p_reg     <= '0;
            alpha_d_reg     <= '0;
            integ_limit_reg <= 31'h7FFF_FFFF;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            integ_reg       <= integ_next;
            last_err_reg    <= last_err_next;
            p_filt_reg      <= p_filt_next;
            d_filt_reg      <= d_filt_next;
            out_max_reg     <= out_max_next;
            out_min_reg     <= out_min_next;
            kp_reg          <= kp_next;
            ki_reg          <= ki_next;
            kd_reg          <= kd_next;
            alpha_p_reg     <= alpha_p_next;
            alpha_d_reg     <= alpha_d_next;
            integ_limit_reg <= integ_limit_next;
        end
    end

    // working values
    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        measured_reg <= measured_next;
        err_reg      <= err_next;
        praw_reg     <= praw_next;
        draw_reg     <= draw_next;
        iterm_reg    <= iterm_next;
        sum_reg      <= sum_next;
        drive_reg    <= drive_next;
    end

`ifndef SYNTHESIS
    // multiplier is never restarted mid-run
    a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_st.busy)
        else $error("multiplier started while busy");

    // a product only lands in a state that waits for one
    a_mul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        mul_st.done |-> (state_reg == fpc_pkg::S_P_MUL || state_reg == fpc_pkg::S_P_BLEND ||
                         state_reg == fpc_pkg::S_I_MUL || state_reg == fpc_pkg::S_D_MUL ||
                         state_reg == fpc_pkg::S_D_BLEND))
        else $error("multiplier result arrived outside a wait state");

    // accepted sample goes straight to error computation
    a_accept_to_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == fpc_pkg::S_ERR)
        else $error("accepted sample did not start processing");

    // filter weights never exceed one
    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        alpha_p_reg <= fpc_pkg::ONE_Q16 && alpha_d_reg <= fpc_pkg::ONE_Q16)
        else $error("filter weight above one");
`endif

endmodule

@@ test/filtered_pid_controller_checker.sv @@
`timescale 1ns / 1ps

// Watches the sample, drive and register channels of the controller, keeps its own
// copy of the settings and of the loop state, and checks every drive value in order.
module filtered_pid_controller_checker
    import fpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic signed [31:0]       target,
    input  logic signed [31:0]       measured,
    input  logic                     restart,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [31:0]       drive,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]              cfg_data,
    output int                       fail_count,
    output int                       pending
);

    // Datapath width is capped at the 32-bit ports
    localparam int DW = (DATA_WIDTH_DEF > 32) ? 32 : DATA_WIDTH_DEF;
    localparam longint WORD_MAX = (64'sd1 <<< (DW - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;
    localparam longint RADIUS = RADIUS_DEF;
    localparam int MAX_REPORTS = 200;

    // Settings
    logic signed [31:0] lim_hi = 32'sh7FFF_FFFF;
    logic signed [31:0] lim_lo = 32'sh8000_0000;
    logic signed [31:0] gain_p = '0;
    logic signed [31:0] gain_i = '0;
    logic signed [31:0] gain_d = '0;
    logic [16:0]        weight_p = '0;
    logic [16:0]        weight_d = '0;
    logic [30:0]        integ_cap = 31'h7FFF_FFFF;

    // Loop state
    longint integ_acc = 0;
    longint prev_error = 0;
    longint p_smooth = 0;
    longint d_smooth = 0;

    logic signed [31:0] drive_q[$];
    logic signed [31:0] want;
    int mismatches = 0;

    function automatic longint clip_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    // First-order blend, weight w on the previous value, rounded toward minus infinity
    function automatic longint low_pass(input logic [16:0] w, input longint prev,
                                        input longint x);
        longint a;
        a = longint'(w);
        return (a * prev + (longint'(ONE_Q16) - a) * x) >>> FRAC_W;
    endfunction

    // Advances the loop state by one sample and returns the clamped drive
    function automatic logic signed [31:0] next_drive(input logic signed [31:0] tgt,
                                                      input logic signed [31:0] meas,
                                                      input logic clear);
        longint err, mag, p_raw, d_raw, i_term, total;
        if (clear)
        begin
            integ_acc = 0;
            prev_error = 0;
            d_smooth = 0;
        end
        err = clip_word(longint'(tgt) - longint'(meas));

        p_raw = clip_word((longint'(gain_p) * err) >>> FRAC_W);
        p_smooth = clip_word(low_pass(weight_p, p_smooth, p_raw));

        // integrate only inside the anti-windup radius, then clamp
        mag = (err < 0) ? -err : err;
        if (mag < RADIUS)
            integ_acc += err;
        if (integ_acc > longint'(integ_cap))
            integ_acc = longint'(integ_cap);
        else if (integ_acc < -longint'(integ_cap))
            integ_acc = -longint'(integ_cap);
        integ_acc = clip_word(integ_acc);
        i_term = (longint'(gain_i) * integ_acc) >>> FRAC_W;

        d_raw = clip_word((longint'(gain_d) * (err - prev_error)) >>> FRAC_W);
        d_smooth = clip_word(low_pass(weight_d, d_smooth, d_raw));

        // crossed bounds: a total above the upper bound gives it, any other the lower bound
        total = p_smooth + i_term + d_smooth;
        if (total > longint'(lim_hi))
            total = longint'(lim_hi);
        else if (total < longint'(lim_lo))
            total = longint'(lim_lo);

        prev_error = err;
        return total[31:0];
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_REPORTS)
            $display("%0t: drive mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // Compare results first, then predict from a new request, then track register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_hi = 32'sh7FFF_FFFF;
            lim_lo = 32'sh8000_0000;
            gain_p = '0;
            gain_i = '0;
            gain_d = '0;
            weight_p = '0;
            weight_d = '0;
            integ_cap = 31'h7FFF_FFFF;
            integ_acc = 0;
            prev_error = 0;
            p_smooth = 0;
            d_smooth = 0;
            drive_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                    report_mismatch($sformatf("got %h with no request outstanding", drive));
                else
                begin
                    want = drive_q.pop_front();
                    if (drive !== want)
                        report_mismatch($sformatf("got %h, expected %h", drive, want));
                end
            end

            if (in_valid && !in_stall)
                drive_q.push_back(next_drive(target, measured, restart));

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OUT_MAX:     lim_hi = cfg_data;
                    CFG_OUT_MIN:     lim_lo = cfg_data;
                    CFG_KP:          gain_p = cfg_data;
                    CFG_KI_TIMES_DT: gain_i = cfg_data;
                    CFG_KD_OVER_DT:  gain_d = cfg_data;
                    CFG_ALPHA_P:     weight_p = (cfg_data[16:0] > ONE_Q16) ? ONE_Q16
                                                                           : cfg_data[16:0];
                    CFG_ALPHA_D:     weight_d = (cfg_data[16:0] > ONE_Q16) ? ONE_Q16
                                                                           : cfg_data[16:0];
                    CFG_INTEG_LIMIT: integ_cap = cfg_data[30:0];
                    default:         ;
                endcase
            end

            pending <= drive_q.size();
        end
        fail_count <= mismatches;
    end

endmodule

@@ test/filtered_pid_controller_test.sv @@
`timescale 1ns / 1ps

module filtered_pid_controller_test;
    import fpc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;
    localparam int RANDOM_PHASES = 12;
    localparam int SAMPLES_PER_PHASE = 150;
    localparam logic [CFG_IDX_W-1:0] SPARE_INDEX = 4'd9;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] RADIUS_Q = RADIUS_DEF;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [31:0]       target = '0;
    logic signed [31:0]       measured = '0;
    logic                     restart = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [31:0]       drive;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [31:0]              cfg_data = '0;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off_asked = 0;
    int hold_off_served = 0;
    int hold_off_left = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    filtered_pid_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .target    (target),
        .measured  (measured),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive     (drive),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    filtered_pid_controller_checker drive_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .target     (target),
        .measured   (measured),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stall, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_off_left == 0 && hold_off_served != hold_off_asked)
        begin
            hold_off_served = hold_off_asked;
            hold_off_left = HOLD_OFF_CYCLES;
        end
        if (hold_off_left > 0)
        begin
            hold_off_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("filtered_pid_controller_test NOT OK");
            $finish;
        end
    end

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic send_sample(input logic signed [31:0] t, input logic signed [31:0] m,
                               input logic r);
        int gap;
        gap = 0;
        if (send_idle_pct != 0)
        begin
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(1, 120);
            else
                while ($urandom_range(0, 99) < send_idle_pct && gap < 40)
                    gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        target <= t;
        measured <= m;
        restart <= r;
        do @(posedge clk); while (in_stall);
    endtask

    // Sender pauses until every expected drive value has come back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic signed [31:0] extreme_word();
        case ($urandom_range(0, 3))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic logic [31:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return $urandom;
            default: return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
        endcase
    endfunction

    // Weight with random upper bits; values above one get clamped by the block
    function automatic logic [31:0] random_weight();
        logic [16:0] w;
        case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = ONE_Q16;
            2:       w = 17'h1_FFFF;
            3:       w = 17'($urandom_range(ONE_Q16 + 1, 17'h1_FFFF));
            default: w = 17'($urandom_range(0, ONE_Q16));
        endcase
        return {15'($urandom), w};
    endfunction

    task automatic load_random_settings();
        logic [31:0] hi, lo;
        case ($urandom_range(0, 5))
            0:       hi = WORD_MAX;
            1:       hi = WORD_MIN;
            2:       hi = $urandom;
            default: hi = $urandom_range(0, 32'h0FFF_FFFF);
        endcase
        case ($urandom_range(0, 5))
            0:       lo = WORD_MIN;
            1:       lo = WORD_MAX;
            2:       lo = $urandom;
            default: lo = -$urandom_range(0, 32'h0FFF_FFFF);
        endcase
        write_reg(CFG_OUT_MAX, hi);
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_KP, random_gain());
        write_reg(CFG_KI_TIMES_DT, random_gain());
        write_reg(CFG_KD_OVER_DT, random_gain());
        write_reg(CFG_ALPHA_P, random_weight());
        write_reg(CFG_ALPHA_D, random_weight());
        case ($urandom_range(0, 4))
            0:       write_reg(CFG_INTEG_LIMIT, '0);
            1:       write_reg(CFG_INTEG_LIMIT, 32'hFFFF_FFFF);
            2:       write_reg(CFG_INTEG_LIMIT, $urandom);
            default: write_reg(CFG_INTEG_LIMIT, {1'($urandom), 31'($urandom_range(0, 32'h8_0000))});
        endcase
        if ($urandom_range(0, 3) == 0)
            write_reg(SPARE_INDEX, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Mostly errors near the anti-windup radius, some full range and extremes
    task automatic send_random_sample();
        logic signed [31:0] t, m;
        case ($urandom_range(0, 9))
            0:
            begin
                t = extreme_word();
                m = extreme_word();
            end
            1, 2:
            begin
                t = $urandom;
                m = $urandom;
            end
            default:
            begin
                m = $urandom;
                t = m + $urandom_range(0, 2 * 32'h2_0000) - 32'h2_0000;
            end
        endcase
        send_sample(t, m, $urandom_range(0, 19) == 0);
    endtask

    initial
    begin
        int phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: all gains zero
        send_sample(WORD_MAX, WORD_MIN, 1'b0);
        wait_for_results();

        // moderate gains, wide bounds, a write to an unused index
        write_reg(CFG_OUT_MAX, WORD_MAX);
        write_reg(CFG_OUT_MIN, WORD_MIN);
        write_reg(CFG_KP, 32'h0001_0000);
        write_reg(CFG_KI_TIMES_DT, 32'h0000_8000);
        write_reg(CFG_KD_OVER_DT, 32'h0000_4000);
        write_reg(CFG_ALPHA_P, 32'h0000_4000);
        write_reg(CFG_ALPHA_D, 32'h0000_8000);
        write_reg(CFG_INTEG_LIMIT, 32'h0003_0000);
        write_reg(SPARE_INDEX, $urandom);
        cfg_valid <= 1'b0;

        // saturating errors, radius edges, integrator limit, restart
        send_sample(WORD_MAX, WORD_MIN, 1'b0);
        send_sample(WORD_MIN, WORD_MAX, 1'b0);
        send_sample('0, '0, 1'b0);
        send_sample(32'sh8000, '0, 1'b0);
        send_sample(RADIUS_Q, '0, 1'b0);
        send_sample('0, RADIUS_Q, 1'b0);
        repeat (4) send_sample(RADIUS_Q - 1, '0, 1'b0);
        send_sample('0, RADIUS_Q - 1, 1'b0);
        send_sample(32'sh1000, '0, 1'b1);
        send_sample(WORD_MAX, WORD_MAX, 1'b1);
        send_sample(WORD_MIN, WORD_MIN, 1'b0);
        wait_for_results();

        // weights above one, extreme gains, crossed bounds, zero integrator limit
        write_reg(CFG_ALPHA_P, {15'($urandom), 17'h1_FFFF});
        write_reg(CFG_ALPHA_D, 32'h0001_0001);
        write_reg(CFG_KP, WORD_MAX);
        write_reg(CFG_KI_TIMES_DT, WORD_MAX);
        write_reg(CFG_KD_OVER_DT, WORD_MIN);
        write_reg(CFG_OUT_MAX, 32'h0000_1000);
        write_reg(CFG_OUT_MIN, 32'h0000_5000);
        write_reg(CFG_INTEG_LIMIT, '0);
        cfg_valid <= 1'b0;

        send_sample(32'sh2_0000, '0, 1'b0);
        send_sample(-32'sh2_0000, '0, 1'b0);
        send_sample('0, '0, 1'b0);
        send_sample(WORD_MAX, WORD_MIN, 1'b0);
        send_sample(WORD_MIN, WORD_MAX, 1'b1);
        wait_for_results();

        // random settings per phase, rotating through the idle and stall modes
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_random_settings();
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 79;
                    hold_off_asked++;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct = 22;
                end
            endcase
            repeat (SAMPLES_PER_PHASE) send_random_sample();
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("filtered_pid_controller_test OK");
        else
            $display("filtered_pid_controller_test NOT OK");
        $finish;
    end

endmodule

@@ filtered_pid_controller.f @@
src/fpc_pkg.sv
src/fpc_serial_mul.sv
src/filtered_pid_controller.sv
test/filtered_pid_controller_checker.sv
test/filtered_pid_controller_test.sv
